@@ sv/wstrim_pkg.sv @@
package wstrim_pkg;

   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_FF    = 8'h0C;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_VT    = 8'h0B;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       stream_end;
      logic       dropped_whitespace;
      logic       last_of_run;
   } rsp_payload_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHR_SPACE) || (b == CHR_FF) || (b == CHR_LF) ||
             (b == CHR_TAB) || (b == CHR_CR) || (b == CHR_VT);
   endfunction

endpackage

@@ sv/wstrim_chan_if.sv @@
interface wstrim_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/whitespace_trim_filter_unit.sv @@
// Channel   Dir  Payload                                              Accepted when
// req_chan  in   data_byte[7:0], is_end                               valid && ready
// rsp_chan  out  out_byte[7:0], stream_end, dropped_whitespace,       valid && ready
//                last_of_run
//
// A whitespace byte or an end marker is handled in the accept state; so is a non-whitespace
// byte with nothing held. A non-whitespace byte that releases N held bytes is accepted,
// then the N held bytes are read out of the pending memory (one read port, one byte per
// cycle while the output register is free), then the byte itself is passed.
// Reset is synchronous, active high; the pending memory needs no clearing.
// A stalled result holds in the output register; the input is taken only when that
// register is free or being emptied in the same cycle.
module whitespace_trim_filter_unit
   import wstrim_pkg::*;
#(
   parameter int PENDING_DEPTH = 16
) (
   input logic clock,
   input logic reset,
   wstrim_chan_if.sink   req_chan,
   wstrim_chan_if.source rsp_chan
);

   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW = $clog2(PENDING_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_ACCEPT = 3'b001,
      ST_FLUSH  = 3'b010,
      ST_LAST   = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            leading_ff, leading_in;
   logic            ovf_ff, ovf_in;
   logic [AW-1:0]   emit_idx_ff, emit_idx_in;
   logic [7:0]      hold_ff, hold_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic [7:0]      pending_mem_ff [PENDING_DEPTH];
   logic [7:0]      rd_data_ff;
   logic [AW-1:0]   rd_addr;
   logic            mem_we;

   logic            out_free;
   logic            req_ready;
   req_payload_type req;

   assign req      = req_chan.payload;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      leading_in   = leading_ff;
      ovf_in       = ovf_ff;
      emit_idx_in  = emit_idx_ff;
      hold_in      = hold_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      mem_we       = 1'b0;
      rd_addr      = emit_idx_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_ACCEPT: begin
            req_ready = out_free;
            if (req_chan.valid && out_free) begin
               priority if (req.is_end) begin
                  // close the stream: report overflow, drop what is held
                  out_valid_in = 1'b1;
                  out_in       = '{8'd0, 1'b1, ovf_ff, 1'b1};
                  leading_in   = 1'b1;
                  count_in     = '0;
                  ovf_in       = 1'b0;
               end else if (is_space(req.data_byte)) begin
                  if (!leading_ff) begin
                     if (count_ff < CW'(PENDING_DEPTH)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               end else begin
                  leading_in = 1'b0;
                  if (count_ff == '0) begin
                     out_valid_in = 1'b1;
                     out_in       = '{req.data_byte, 1'b0, 1'b0, 1'b1};
                  end else begin
                     // park the byte, start reading the held run from entry zero
                     hold_in     = req.data_byte;
                     emit_idx_in = '0;
                     rd_addr     = '0;
                     state_in    = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{rd_data_ff, 1'b0, 1'b0, 1'b0};
               if (CW'(emit_idx_ff) + CW'(1) == count_ff) begin
                  state_in = ST_LAST;
               end else begin
                  emit_idx_in = emit_idx_ff + AW'(1);
                  rd_addr     = emit_idx_ff + AW'(1);
               end
            end
         end
         ST_LAST: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{hold_ff, 1'b0, 1'b0, 1'b1};
               count_in     = '0;
               state_in     = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   // pending memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pending_mem_ff[count_ff[AW-1:0]] <= req.data_byte;
      end
      rd_data_ff <= pending_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         count_ff     <= '0;
         leading_ff   <= 1'b1;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         leading_ff   <= leading_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_idx_ff <= emit_idx_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

`ifndef SYNTH
   // held count never passes the memory depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PENDING_DEPTH))
      else $error("pending count above depth");

   // readout index stays inside the held run
   a_flush_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (CW'(emit_idx_ff) < count_ff))
      else $error("flush index outside held run");

   // a released run starts a flush
   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready && !req.is_end && !is_space(req.data_byte) &&
       count_ff != '0) |=> (state_ff == ST_FLUSH))
      else $error("held run not flushed");

   // the end result always closes its run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.stream_end) |-> out_ff.last_of_run)
      else $error("end result without last_of_run");

   // no memory write while the held run is read out
   a_no_write_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACCEPT) |-> !mem_we)
      else $error("pending write during flush");
`endif

endmodule

@@ test/whitespace_trim_filter_unit_tb.sv @@
`timescale 1ns / 100ps

module whitespace_trim_filter_unit_tb;
   import wstrim_pkg::*;

   localparam int HOLD_DEPTH   = 16;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 400;
   localparam int LONG_HOLDOFF = 300;
   localparam int QUIET_ITEMS  = 80;

   // Typed-in results for rows whose outcome is plain from the rules.
   localparam rsp_payload_type END_CLEAN = '{8'h00, 1'b1, 1'b0, 1'b1};
   localparam rsp_payload_type END_LOST  = '{8'h00, 1'b1, 1'b1, 1'b1};
   localparam rsp_payload_type NO_TYPED  = '0;

   typedef struct {
      logic [7:0]      data_val;
      logic            end_mark;
      int unsigned     reps;
      bit              typed;
      rsp_payload_type typed_rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wstrim_chan_if #(.payload_type(req_payload_type)) req_if ();
   wstrim_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   whitespace_trim_filter_unit #(
      .PENDING_DEPTH(HOLD_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #4 clock = ~clock;

   // Predictor state: its own copy of the trim filter.
   bit              pred_leading = 1'b1;
   logic [7:0]      pred_held[$];
   bit              pred_overflow = 1'b0;
   rsp_payload_type step_rsp[$];

   // Results still owed by the block, oldest first.
   rsp_payload_type expected_rsp_q[$];

   req_payload_type stim_q[$];
   int              error_count = 0;
   int              cycle_count = 0;
   bit              quiet_mode = 1'b0;
   bit              rsp_hold_req = 1'b0;

   // Directed rows: leading run of every whitespace code, extremes of the data byte,
   // end on an empty stream, end with held bytes, overflow and its sticky flag,
   // and a completely full hold buffer released in one go.
   dir_row_type directed_table [24] = '{
      '{8'h00,     1'b1, 1,  1'b1, END_CLEAN},
      '{CHR_SPACE, 1'b0, 1,  1'b0, NO_TYPED},
      '{CHR_FF,    1'b0, 1,  1'b0, NO_TYPED},
      '{CHR_LF,    1'b0, 1,  1'b0, NO_TYPED},
      '{CHR_TAB,   1'b0, 1,  1'b0, NO_TYPED},
      '{CHR_CR,    1'b0, 1,  1'b0, NO_TYPED},
      '{CHR_VT,    1'b0, 1,  1'b0, NO_TYPED},
      '{8'h41,     1'b0, 1,  1'b1, '{8'h41, 1'b0, 1'b0, 1'b1}},
      '{CHR_SPACE, 1'b0, 1,  1'b0, NO_TYPED},
      '{CHR_TAB,   1'b0, 1,  1'b0, NO_TYPED},
      '{8'h42,     1'b0, 1,  1'b0, NO_TYPED},
      '{8'h00,     1'b0, 1,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
      '{8'hFF,     1'b0, 1,  1'b1, '{8'hFF, 1'b0, 1'b0, 1'b1}},
      '{CHR_CR,    1'b0, 1,  1'b0, NO_TYPED},
      '{8'hFF,     1'b1, 1,  1'b1, END_CLEAN},
      '{8'h78,     1'b0, 1,  1'b1, '{8'h78, 1'b0, 1'b0, 1'b1}},
      '{CHR_SPACE, 1'b0, 17, 1'b0, NO_TYPED},
      '{CHR_LF,    1'b0, 1,  1'b0, NO_TYPED},
      '{8'h62,     1'b0, 1,  1'b0, NO_TYPED},
      '{CHR_SPACE, 1'b1, 1,  1'b1, END_LOST},
      '{8'h79,     1'b0, 1,  1'b1, '{8'h79, 1'b0, 1'b0, 1'b1}},
      '{CHR_TAB,   1'b0, 16, 1'b0, NO_TYPED},
      '{8'h7A,     1'b0, 1,  1'b0, NO_TYPED},
      '{CHR_VT,    1'b1, 1,  1'b1, END_CLEAN}
   };

   function automatic bit is_blank(input logic [7:0] v);
      return v == CHR_SPACE || v == CHR_FF || v == CHR_LF ||
             v == CHR_TAB || v == CHR_CR || v == CHR_VT;
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 5))
         0: return CHR_SPACE;
         1: return CHR_FF;
         2: return CHR_LF;
         3: return CHR_TAB;
         4: return CHR_CR;
         default: return CHR_VT;
      endcase
   endfunction

   function automatic logic [7:0] pick_text();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (is_blank(v));
      return v;
   endfunction

   // Work out the results one request causes and advance the predictor state.
   function void trim_filter_predict(input req_payload_type r);
      step_rsp.delete();
      if (r.is_end) begin
         step_rsp.push_back('{8'h00, 1'b1, pred_overflow, 1'b1});
         pred_leading  = 1'b1;
         pred_overflow = 1'b0;
         pred_held.delete();
      end else if (is_blank(r.data_byte)) begin
         // drop leading whitespace; hold interior whitespace until the buffer fills
         if (!pred_leading) begin
            if (pred_held.size() < HOLD_DEPTH) pred_held.push_back(r.data_byte);
            else pred_overflow = 1'b1;
         end
      end else begin
         pred_leading = 1'b0;
         foreach (pred_held[i]) step_rsp.push_back('{pred_held[i], 1'b0, 1'b0, 1'b0});
         pred_held.delete();
         step_rsp.push_back('{r.data_byte, 1'b0, 1'b0, 1'b1});
      end
   endfunction

   // Offer one request, hold it until taken, then record what it must produce.
   task automatic send_request(input req_payload_type r, input bit typed,
                               input rsp_payload_type typed_rsp);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      trim_filter_predict(r);
      if (typed) expected_rsp_q.push_back(typed_rsp);
      else foreach (step_rsp[i]) expected_rsp_q.push_back(step_rsp[i]);
   endtask

   // Stop offering and wait until every owed result has come back.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Build the random part: mostly well-formed streams (text words split by
   // whitespace runs, some long enough to overflow), with raw noise mixed in.
   task automatic build_random_streams();
      int counted;
      int words;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(3, 12)) begin
               stim_q.push_back('{8'($urandom_range(0, 255)),
                                  $urandom_range(0, 9) == 0});
               counted++;
            end
         end else begin
            // leading whitespace, dropped by the block
            repeat ($urandom_range(0, 3)) begin
               stim_q.push_back('{pick_blank(), 1'b0});
               counted++;
            end
            words = $urandom_range(1, 6);
            for (int w = 0; w < words; w++) begin
               repeat ($urandom_range(1, 5)) begin
                  stim_q.push_back('{pick_text(), 1'b0});
                  counted++;
               end
               repeat (($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
                                                   : $urandom_range(0, 3)) begin
                  stim_q.push_back('{pick_blank(), 1'b0});
                  counted++;
               end
            end
            stim_q.push_back('{8'($urandom_range(0, 255)), 1'b1});
            counted++;
         end
      end
   endtask

   function void check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Compare every accepted result with the oldest one owed.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p",
                     $time, rsp_if.payload);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_if.payload.out_byte);
            check_field("stream_end", 8'(want.stream_end),
                        8'(rsp_if.payload.stream_end));
            check_field("dropped_whitespace", 8'(want.dropped_whitespace),
                        8'(rsp_if.payload.dropped_whitespace));
            check_field("last_of_run", 8'(want.last_of_run),
                        8'(rsp_if.payload.last_of_run));
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, none when quiet.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLDOFF) @(posedge clock);
         end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if the block hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      build_random_streams();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_table[i]) begin
         for (int k = 0; k < directed_table[i].reps; k++) begin
            send_request('{directed_table[i].data_val, directed_table[i].end_mark},
                         directed_table[i].typed, directed_table[i].typed_rsp);
         end
      end

      // Random part: hold off the receiver early so the block backs up into the
      // input, pause the sender midway until drained, run the tail with no idling.
      foreach (stim_q[idx]) begin
         if (idx == stim_q.size() / 5) rsp_hold_req = 1'b1;
         if (idx == stim_q.size() / 2) wait_drained();
         if (idx == stim_q.size() - QUIET_ITEMS) quiet_mode = 1'b1;
         send_request(stim_q[idx], 1'b0, NO_TYPED);
      end

      wait_drained();
      repeat (HOLD_DEPTH + 8) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ whitespace_trim_filter_unit.f @@
sv/wstrim_pkg.sv
sv/wstrim_chan_if.sv
sv/whitespace_trim_filter_unit.sv
test/whitespace_trim_filter_unit_tb.sv
